// ----- src/ddo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and helpers of the oscillator step core
// Beat payloads, configuration register indexes, sequencer states, the
// saturating clamps and the elaboration-time cosine table generator.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // Input and result beats.
  typedef struct packed {
    logic               operation;
    logic signed [31:0] initial_position;
    logic signed [31:0] initial_velocity;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        step_index;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic [31:0]        energy;
    logic               saturated;
  } out_item_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_INVERSE_STEP  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS_PER_MASS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_PER_MASS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FORCE_PER_MASS     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INCREMENT    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET       = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MASS               = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC1, ST_ACC2, ST_ACC3, ST_ACC4, ST_ACC5,
    ST_AD1,  ST_AD2,  ST_AD3,  ST_AD4,
    ST_X1,   ST_X2,   ST_DIFF,
    ST_V1,   ST_V2,   ST_V3,   ST_V4,
    ST_E1,   ST_E2,   ST_E3
  } state_t;

  // Multiplier operands are 33-bit signed so that unsigned 32-bit values fit.
  typedef logic signed [32:0] opd_t;

  // Wide signed value for exact products, rounding and multi-term sums.
  typedef logic signed [66:0] wide_t;

  typedef struct packed {
    logic extra_shift;     // round away one more fraction bit (halving)
    logic unsigned_clamp;  // clamp to the unsigned 32-bit range
  } mul_ctl_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } sat_val_t;

  localparam wide_t S32_MAX = 67'sh0_7FFF_FFFF;
  localparam wide_t S32_MIN = -67'sh0_8000_0000;
  localparam wide_t U32_MAX = 67'sh0_FFFF_FFFF;

  function automatic sat_val_t sat_s32(wide_t v);
    sat_val_t r;
    r.sat   = 1'b0;
    r.value = v[31:0];
    if (v > S32_MAX) begin
      r.value = 32'h7FFF_FFFF;
      r.sat   = 1'b1;
    end else if (v < S32_MIN) begin
      r.value = 32'h8000_0000;
      r.sat   = 1'b1;
    end
    return r;
  endfunction

  function automatic sat_val_t sat_u32(wide_t v);
    sat_val_t r;
    r.sat   = 1'b0;
    r.value = v[31:0];
    if (v > U32_MAX) begin
      r.value = 32'hFFFF_FFFF;
      r.sat   = 1'b1;
    end
    return r;
  endfunction

  function automatic opd_t opd_s(logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic opd_t opd_u(logic [31:0] v);
    return {1'b0, v};
  endfunction

  function automatic opd_t opd_abs(logic signed [31:0] v);
    opd_t e;
    e = {v[31], v};
    return v[31] ? -e : e;
  endfunction

  // Cosine table generation, evaluated at elaboration only.
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint Q30_ONE     = 64'd1 << 30;
  localparam longint TAYLOR_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

  // Nested Taylor series of cos in Q2.30, rounded to fb fraction bits.
  function automatic longint cos_entry(longint angle, int fb);
    longint x2;
    longint t;
    longint p;
    int     k;
    x2 = (angle * angle) >>> 30;
    t  = Q30_ONE;
    for (k = 0; k < 7; k++) begin
      p = (t > 0) ? ((x2 * t) >>> 30) / TAYLOR_DIV[k] : 64'd0;
      t = Q30_ONE - p;
    end
    if (t < 0) begin
      t = 0;
    end
    t = (t + (64'sd1 <<< (29 - fb))) >>> (30 - fb);
    if (t > (64'sd1 <<< fb)) begin
      t = 64'sd1 <<< fb;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- src/driven_damped_oscillator_verlet_step_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// driven_damped_oscillator_verlet_step_core: forced damped oscillator stepper
// Position Verlet integration of x'' = -(k/m)x - (b/m)v + (F/m)cos(phase) in
// signed fixed point, with one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload              Beat
//  in_      in_valid / in_ready  in_data (in_item_t)  one start or step item
//  out_     out_valid/out_ready  out_data(out_item_t) one result per step item
//  cfg_     cfg_we               cfg_index, cfg_data  one register write
//
// A start beat keeps the core busy through the ACC, AD and X1 states and gives
// no result; a step beat runs through the ACC, AD, X2, DIFF, V and E states,
// a chain of dependent multiplications through the single shared multiplier.
// Reset is synchronous and active low; it loads the register defaults and
// clears the oscillator state. in_ready is high only while the sequencer is
// idle. A result waits in the output register; a new step stalls in its last
// cycle only while the previous result has not yet been taken.
// ----------------------------------------------------------------------------
module driven_damped_oscillator_verlet_step_core #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS   = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  ddo_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output ddo_pkg::out_item_t                   out_data,
  input  wire                                  cfg_we,
  input  wire  [ddo_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [31:0]                          cfg_data
);

  // Configuration registers.
  logic [30:0]        time_step_r;
  logic [30:0]        half_inverse_step_r;
  logic [30:0]        stiffness_per_mass_r;
  logic [30:0]        damping_per_mass_r;
  logic signed [31:0] force_per_mass_r;
  logic [15:0]        phase_increment_r;
  logic [15:0]        phase_offset_r;
  logic [30:0]        mass_r;

  // Oscillator state carried from step to step.
  logic signed [31:0] previous_position_r;
  logic signed [31:0] current_position_r;
  logic signed [31:0] current_velocity_r;
  logic [15:0]        drive_phase_r;
  logic [31:0]        step_count_r;

  // Sequencer and working registers of the item in flight.
  ddo_pkg::state_t    state_r;
  ddo_pkg::state_t    state_nxt;
  logic               op_r;
  logic               sat_r;
  logic signed [31:0] term_a_r;   // (k/m) x
  logic signed [31:0] term_b_r;   // (b/m) v
  logic signed [31:0] term_c_r;   // (F/m) cos
  logic signed [31:0] accel_r;
  logic signed [31:0] ad_r;       // a dt
  logic [31:0]        t1_r;       // v dt on start, x1 squared on step
  logic signed [31:0] t2_r;       // a dt^2 (halved on start)
  logic [31:0]        kk_r;       // (k/m) m
  logic [31:0]        hp2_r;      // spring energy
  logic [31:0]        hp1_r;      // kinetic energy
  logic signed [31:0] x2_r;
  logic signed [31:0] diff_r;
  logic signed [31:0] vel_r;
  logic [31:0]        vv_r;

  logic               out_valid_r;
  ddo_pkg::out_item_t out_data_r;

  // Shared multiplier and cosine lookup.
  ddo_pkg::opd_t      mul_a;
  ddo_pkg::opd_t      mul_b;
  ddo_pkg::mul_ctl_t  mul_ctl;
  ddo_pkg::sat_val_t  mul_rsp;
  logic signed [31:0] cos_value;

  logic               in_fire;
  logic               is_start;
  logic               out_free;
  logic               finish_step;
  logic [15:0]        lookup_phase;

  ddo_pkg::sat_val_t  accel_sum;
  ddo_pkg::sat_val_t  x1_sum;
  ddo_pkg::sat_val_t  x2_sum;
  ddo_pkg::sat_val_t  diff_sum;
  ddo_pkg::sat_val_t  energy_sum;

  assign in_ready    = (state_r == ddo_pkg::ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign is_start    = (op_r == ddo_pkg::OP_START);
  assign out_free    = !out_valid_r || out_ready;
  assign finish_step = (state_r == ddo_pkg::ST_E3) && out_free;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  // A start drives from the phase offset alone; a step adds the accumulator.
  assign lookup_phase = (in_data.operation == ddo_pkg::OP_START)
                      ? phase_offset_r : phase_offset_r + drive_phase_r;

  ddo_mul_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .ctl  (mul_ctl),
    .rsp  (mul_rsp)
  );

  ddo_cos_rom #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_cos (
    .clk       (clk),
    .load      (in_fire),
    .phase     (lookup_phase),
    .cos_value (cos_value)
  );

  // Sums of the integration, each clamped to 32 bits as a whole.
  always_comb begin
    accel_sum  = ddo_pkg::sat_s32(ddo_pkg::wide_t'(term_c_r) - ddo_pkg::wide_t'(term_a_r)
                                  - ddo_pkg::wide_t'(term_b_r));
    x1_sum     = ddo_pkg::sat_s32(ddo_pkg::wide_t'(previous_position_r)
                                  + ddo_pkg::wide_t'($signed(t1_r))
                                  + ddo_pkg::wide_t'(t2_r));
    x2_sum     = ddo_pkg::sat_s32(ddo_pkg::wide_t'(current_position_r)
                                  + ddo_pkg::wide_t'(current_position_r)
                                  - ddo_pkg::wide_t'(previous_position_r)
                                  + ddo_pkg::wide_t'(t2_r));
    diff_sum   = ddo_pkg::sat_s32(ddo_pkg::wide_t'(x2_r)
                                  - ddo_pkg::wide_t'(previous_position_r));
    energy_sum = ddo_pkg::sat_u32(ddo_pkg::wide_t'(hp1_r) + ddo_pkg::wide_t'(hp2_r));
  end

  // Sequencer: each state may issue one multiplication and picks up the
  // result of the one issued in the state before.
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    mul_ctl   = '0;
    unique case (state_r)
      ddo_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ddo_pkg::ST_ACC1;
        end
      end
      ddo_pkg::ST_ACC1: begin
        mul_a     = ddo_pkg::opd_u({1'b0, stiffness_per_mass_r});
        mul_b     = is_start ? ddo_pkg::opd_s(previous_position_r)
                             : ddo_pkg::opd_s(current_position_r);
        state_nxt = ddo_pkg::ST_ACC2;
      end
      ddo_pkg::ST_ACC2: begin
        mul_a     = ddo_pkg::opd_u({1'b0, damping_per_mass_r});
        mul_b     = ddo_pkg::opd_s(current_velocity_r);
        state_nxt = ddo_pkg::ST_ACC3;
      end
      ddo_pkg::ST_ACC3: begin
        mul_a     = ddo_pkg::opd_s(force_per_mass_r);
        mul_b     = ddo_pkg::opd_s(cos_value);
        state_nxt = ddo_pkg::ST_ACC4;
      end
      ddo_pkg::ST_ACC4: begin
        if (is_start) begin
          mul_a = ddo_pkg::opd_s(current_velocity_r);
          mul_b = ddo_pkg::opd_u({1'b0, time_step_r});
        end else begin
          mul_a = ddo_pkg::opd_abs(current_position_r);
          mul_b = ddo_pkg::opd_abs(current_position_r);
          mul_ctl.unsigned_clamp = 1'b1;
        end
        state_nxt = ddo_pkg::ST_ACC5;
      end
      ddo_pkg::ST_ACC5: begin
        if (!is_start) begin
          mul_a = ddo_pkg::opd_u({1'b0, stiffness_per_mass_r});
          mul_b = ddo_pkg::opd_u({1'b0, mass_r});
          mul_ctl.unsigned_clamp = 1'b1;
        end
        state_nxt = ddo_pkg::ST_AD1;
      end
      ddo_pkg::ST_AD1: begin
        mul_a     = ddo_pkg::opd_s(accel_r);
        mul_b     = ddo_pkg::opd_u({1'b0, time_step_r});
        state_nxt = ddo_pkg::ST_AD2;
      end
      ddo_pkg::ST_AD2: begin
        if (!is_start) begin
          mul_a = ddo_pkg::opd_u(kk_r);
          mul_b = ddo_pkg::opd_u(t1_r);
          mul_ctl = '{extra_shift: 1'b1, unsigned_clamp: 1'b1};
        end
        state_nxt = ddo_pkg::ST_AD3;
      end
      ddo_pkg::ST_AD3: begin
        mul_a = ddo_pkg::opd_s(ad_r);
        mul_b = ddo_pkg::opd_u({1'b0, time_step_r});
        mul_ctl.extra_shift = is_start;
        state_nxt = ddo_pkg::ST_AD4;
      end
      ddo_pkg::ST_AD4: begin
        state_nxt = is_start ? ddo_pkg::ST_X1 : ddo_pkg::ST_X2;
      end
      ddo_pkg::ST_X1: begin
        state_nxt = ddo_pkg::ST_IDLE;
      end
      ddo_pkg::ST_X2: begin
        state_nxt = ddo_pkg::ST_DIFF;
      end
      ddo_pkg::ST_DIFF: begin
        state_nxt = ddo_pkg::ST_V1;
      end
      ddo_pkg::ST_V1: begin
        mul_a     = ddo_pkg::opd_s(diff_r);
        mul_b     = ddo_pkg::opd_u({1'b0, half_inverse_step_r});
        state_nxt = ddo_pkg::ST_V2;
      end
      ddo_pkg::ST_V2: begin
        state_nxt = ddo_pkg::ST_V3;
      end
      ddo_pkg::ST_V3: begin
        mul_a     = ddo_pkg::opd_abs(vel_r);
        mul_b     = ddo_pkg::opd_abs(vel_r);
        mul_ctl.unsigned_clamp = 1'b1;
        state_nxt = ddo_pkg::ST_V4;
      end
      ddo_pkg::ST_V4: begin
        state_nxt = ddo_pkg::ST_E1;
      end
      ddo_pkg::ST_E1: begin
        mul_a     = ddo_pkg::opd_u({1'b0, mass_r});
        mul_b     = ddo_pkg::opd_u(vv_r);
        mul_ctl   = '{extra_shift: 1'b1, unsigned_clamp: 1'b1};
        state_nxt = ddo_pkg::ST_E2;
      end
      ddo_pkg::ST_E2: begin
        state_nxt = ddo_pkg::ST_E3;
      end
      ddo_pkg::ST_E3: begin
        if (out_free) begin
          state_nxt = ddo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ddo_pkg::ST_IDLE;
      end
    endcase
  end

  // Working registers pick up multiplier results and sums as the sequence
  // goes; the saturation flag collects every clip of a step item.
  always_ff @(posedge clk) begin
    case (state_r)
      ddo_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_r  <= in_data.operation;
          sat_r <= 1'b0;
        end
      end
      ddo_pkg::ST_ACC2: begin
        term_a_r <= $signed(mul_rsp.value);
        sat_r    <= sat_r | mul_rsp.sat;
      end
      ddo_pkg::ST_ACC3: begin
        term_b_r <= $signed(mul_rsp.value);
        sat_r    <= sat_r | mul_rsp.sat;
      end
      ddo_pkg::ST_ACC4: begin
        term_c_r <= $signed(mul_rsp.value);
        sat_r    <= sat_r | mul_rsp.sat;
      end
      ddo_pkg::ST_ACC5: begin
        accel_r <= $signed(accel_sum.value);
        t1_r    <= mul_rsp.value;
        sat_r   <= sat_r | accel_sum.sat | mul_rsp.sat;
      end
      ddo_pkg::ST_AD1: begin
        kk_r  <= mul_rsp.value;
        sat_r <= sat_r | (!is_start && mul_rsp.sat);
      end
      ddo_pkg::ST_AD2: begin
        ad_r  <= $signed(mul_rsp.value);
        sat_r <= sat_r | mul_rsp.sat;
      end
      ddo_pkg::ST_AD3: begin
        hp2_r <= mul_rsp.value;
        sat_r <= sat_r | (!is_start && mul_rsp.sat);
      end
      ddo_pkg::ST_AD4: begin
        t2_r  <= $signed(mul_rsp.value);
        sat_r <= sat_r | mul_rsp.sat;
      end
      ddo_pkg::ST_X2: begin
        x2_r  <= $signed(x2_sum.value);
        sat_r <= sat_r | x2_sum.sat;
      end
      ddo_pkg::ST_DIFF: begin
        diff_r <= $signed(diff_sum.value);
        sat_r  <= sat_r | diff_sum.sat;
      end
      ddo_pkg::ST_V2: begin
        vel_r <= $signed(mul_rsp.value);
        sat_r <= sat_r | mul_rsp.sat;
      end
      ddo_pkg::ST_V4: begin
        vv_r  <= mul_rsp.value;
        sat_r <= sat_r | mul_rsp.sat;
      end
      ddo_pkg::ST_E2: begin
        hp1_r <= mul_rsp.value;
        sat_r <= sat_r | mul_rsp.sat;
      end
      default: begin
      end
    endcase

    if (finish_step) begin
      out_data_r.step_index   <= step_count_r;
      out_data_r.position     <= current_position_r;
      out_data_r.velocity     <= vel_r;
      out_data_r.acceleration <= accel_r;
      out_data_r.energy       <= energy_sum.value;
      out_data_r.saturated    <= sat_r | energy_sum.sat;
    end
  end

  // Sequencer state, configuration, oscillator state and the result flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ddo_pkg::ST_IDLE;
      out_valid_r          <= 1'b0;
      time_step_r          <= 31'd655;
      half_inverse_step_r  <= 31'd3276800;
      stiffness_per_mass_r <= 31'd65536;
      damping_per_mass_r   <= 31'd0;
      force_per_mass_r     <= 32'sd0;
      phase_increment_r    <= 16'd0;
      phase_offset_r       <= 16'd0;
      mass_r               <= 31'd65536;
      previous_position_r  <= 32'sd0;
      current_position_r   <= 32'sd0;
      current_velocity_r   <= 32'sd0;
      drive_phase_r        <= 16'd0;
      step_count_r         <= 32'd0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          ddo_pkg::REG_TIME_STEP:          time_step_r          <= cfg_data[30:0];
          ddo_pkg::REG_HALF_INVERSE_STEP:  half_inverse_step_r  <= cfg_data[30:0];
          ddo_pkg::REG_STIFFNESS_PER_MASS: stiffness_per_mass_r <= cfg_data[30:0];
          ddo_pkg::REG_DAMPING_PER_MASS:   damping_per_mass_r   <= cfg_data[30:0];
          ddo_pkg::REG_FORCE_PER_MASS:     force_per_mass_r     <= $signed(cfg_data);
          ddo_pkg::REG_PHASE_INCREMENT:    phase_increment_r    <= cfg_data[15:0];
          ddo_pkg::REG_PHASE_OFFSET:       phase_offset_r       <= cfg_data[15:0];
          ddo_pkg::REG_MASS:               mass_r               <= cfg_data[30:0];
        endcase
      end

      // A start loads the initial conditions at once; its first position
      // lands when the Taylor step completes.
      if (in_fire && (in_data.operation == ddo_pkg::OP_START)) begin
        previous_position_r <= in_data.initial_position;
        current_velocity_r  <= in_data.initial_velocity;
        drive_phase_r       <= 16'd0;
        step_count_r        <= 32'd0;
      end

      if (state_r == ddo_pkg::ST_X1) begin
        current_position_r <= $signed(x1_sum.value);
      end

      // A finished step shifts the position history and advances the drive.
      if (finish_step) begin
        previous_position_r <= current_position_r;
        current_position_r  <= x2_r;
        current_velocity_r  <= vel_r;
        drive_phase_r       <= drive_phase_r + phase_increment_r;
        step_count_r        <= step_count_r + 32'd1;
      end

      if (finish_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A start item runs a fixed sequence and returns to idle without a result.
  a_start_length: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.operation == ddo_pkg::OP_START)) |->
      ##11 (state_r == ddo_pkg::ST_IDLE))
    else $error("start sequence did not return to idle in time");

  // The last step state holds while the previous result is still pending.
  a_e3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ddo_pkg::ST_E3) && out_valid_r && !out_ready) |=>
      (state_r == ddo_pkg::ST_E3))
    else $error("step finished over an untaken result");

  // Every finished step presents its result on the next cycle.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    finish_step |=> out_valid_r)
    else $error("finished step did not raise out_valid");

  // The step counter advances by exactly one per result.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    finish_step |=> (step_count_r == $past(step_count_r) + 32'd1))
    else $error("step counter did not advance by one");

endmodule
`default_nettype wire

// ----- src/ddo_mul_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mul_unit: shared multiplier with rounding and clamping
// Registers the exact 33x33 product, then rounds half up at FRACTION_BITS
// (or one more bit) and clamps to the signed or unsigned 32-bit range.
// ----------------------------------------------------------------------------
module ddo_mul_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  wire                 clk,
  input  ddo_pkg::opd_t       op_a,
  input  ddo_pkg::opd_t       op_b,
  input  ddo_pkg::mul_ctl_t   ctl,
  output ddo_pkg::sat_val_t   rsp
);

  localparam ddo_pkg::wide_t RND_N = ddo_pkg::wide_t'(1) <<< (FRACTION_BITS - 1);
  localparam ddo_pkg::wide_t RND_X = ddo_pkg::wide_t'(1) <<< FRACTION_BITS;

  logic signed [65:0] product_r;
  ddo_pkg::mul_ctl_t  ctl_r;
  ddo_pkg::wide_t     rnd_sum;
  ddo_pkg::wide_t     shifted;

  always_ff @(posedge clk) begin
    product_r <= op_a * op_b;
    ctl_r     <= ctl;
  end

  // The result is read in the cycle after the operands were presented.
  always_comb begin
    rnd_sum = ddo_pkg::wide_t'(product_r) + (ctl_r.extra_shift ? RND_X : RND_N);
    shifted = ctl_r.extra_shift ? (rnd_sum >>> (FRACTION_BITS + 1))
                                : (rnd_sum >>> FRACTION_BITS);
    rsp     = ctl_r.unsigned_clamp ? ddo_pkg::sat_u32(shifted) : ddo_pkg::sat_s32(shifted);
  end

endmodule
`default_nettype wire

// ----- src/ddo_cos_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cos_rom: quarter-wave cosine lookup
// Maps a 16-bit phase onto a quarter-wave table with registered read and
// applies the quadrant mirror and sign.
// ----------------------------------------------------------------------------
module ddo_cos_rom #(
  parameter int COS_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS   = 16
) (
  input  wire                clk,
  input  wire                load,
  input  wire  [15:0]        phase,
  output logic signed [31:0] cos_value
);

  localparam int AW = $clog2(COS_TABLE_DEPTH);
  localparam int EW = FRACTION_BITS + 1;
  localparam int SW = 14 + AW + 1;

  logic [EW-1:0] rom [COS_TABLE_DEPTH];

  for (genvar gi = 0; gi < COS_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint ANGLE = (longint'(gi) * ddo_pkg::HALF_PI_Q30) / COS_TABLE_DEPTH;
    assign rom[gi] = EW'(ddo_pkg::cos_entry(ANGLE, FRACTION_BITS));
  end

  logic [SW-1:0] scaled;
  logic [AW:0]   idx_full;
  logic [AW-1:0] idx;
  logic [AW:0]   mir;
  logic [AW-1:0] addr;
  logic          mirrored;

  logic [EW-1:0] rom_q_r;
  logic          neg_r;
  logic          zero_r;
  logic signed [31:0] mag;

  always_comb begin
    scaled   = SW'(phase[13:0]) * SW'(COS_TABLE_DEPTH);
    idx_full = scaled[SW-1:14];
    idx      = idx_full[AW-1:0];
    mir      = (AW+1)'(COS_TABLE_DEPTH) - {1'b0, idx};
    mirrored = phase[14];
    addr     = mirrored ? mir[AW-1:0] : idx;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rom_q_r <= rom[addr];
      neg_r   <= phase[15] ^ phase[14];
      // The mirrored entry one past the table end reads as zero.
      zero_r  <= mirrored && (idx == '0);
    end
  end

  always_comb begin
    mag       = zero_r ? 32'sd0 : $signed({{(32-EW){1'b0}}, rom_q_r});
    cos_value = neg_r ? -mag : mag;
  end

endmodule
`default_nettype wire

// ----- tb/sv/driven_damped_oscillator_verlet_step_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// driven_damped_oscillator_verlet_step_core_tb: self-checking oscillator bench
// Drives start and step beats into the Verlet step core under random idling
// on both channels. It rewrites the registers between phases and predicts
// every result beat with a bit-exact fixed-point integrator of its own. Each
// result beat is compared field by field, in order, with that prediction.
// ----------------------------------------------------------------------------
module driven_damped_oscillator_verlet_step_core_tb;
  import ddo_pkg::*;

  // Fixed-point format and cosine table size; these match the core defaults.
  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = 1024;

  // The settle wait after the last result is long enough for a start beat
  // still in flight to retire.
  localparam int SETTLE_CYCLES  = 40;
  localparam int RUN_LIMIT      = 1000000;
  localparam int ITEMS_PER_MODE = 560;

  localparam longint SQ_HI = 64'sd2147483647;
  localparam longint SQ_LO = -64'sd2147483648;
  localparam logic [63:0] UQ_HI = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] U31_MAX = 32'h7FFF_FFFF;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  // Every input of the core holds a known value from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  driven_damped_oscillator_verlet_step_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the register file, as the core holds it after each write.
  logic [30:0]        dt_q;
  logic [30:0]        half_inv_q;
  logic [30:0]        k_over_m;
  logic [30:0]        b_over_m;
  logic signed [31:0] f_over_m;
  logic [15:0]        phase_step;
  logic [15:0]        phase_zero;
  logic [30:0]        mass_q;

  // Local copy of the oscillator state: two positions for the Verlet update,
  // the last velocity for damping, the drive phase and the step counter.
  logic signed [31:0] x_prev;
  logic signed [31:0] x_now;
  logic signed [31:0] v_now;
  logic [15:0]        drive_ph;
  logic [31:0]        step_ctr;

  logic signed [31:0] cos_rom [TABLE_DEPTH];

  // Set by any clamp while one beat is being worked out.
  bit clip_flag;

  // Results predicted for accepted step beats, oldest first.
  out_item_t pending_steps[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // --------------------------------------------------------------------------
  // Fixed-point arithmetic of the integrator
  // --------------------------------------------------------------------------

  function automatic logic signed [31:0] clip_s32(longint v);
    if (v > SQ_HI) begin
      clip_flag = 1'b1;
      return POS_MAX;
    end
    if (v < SQ_LO) begin
      clip_flag = 1'b1;
      return POS_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] clip_u32(logic [63:0] v);
    if (v > UQ_HI) begin
      clip_flag = 1'b1;
      return UQ_HI;
    end
    return v;
  endfunction

  // Exact product, then rounded half up while dropping shift bits. The
  // arithmetic shift floors, which together with the added half gives the
  // round toward plus infinity that the core uses for ties.
  function automatic logic signed [31:0] q_mul(logic signed [31:0] a,
                                               logic signed [31:0] b, int shift);
    longint p;
    p = a * b;
    p = p + (64'sd1 <<< (shift - 1));
    return clip_s32(p >>> shift);
  endfunction

  function automatic logic [63:0] q_square(logic signed [31:0] v);
    logic [63:0] mag;
    mag = {32'd0, v[31] ? -v : v};
    return clip_u32((mag * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  endfunction

  // Half of a product, rounded: one more bit goes in the final shift.
  function automatic logic [63:0] q_half_product(logic [63:0] a, logic [63:0] b);
    return clip_u32((a * b + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1));
  endfunction

  // One quarter-wave entry: the cosine Taylor series through x^14 in Q2.30,
  // nested from the highest term down, each division truncating.
  function automatic logic signed [31:0] taylor_cos_entry(int idx);
    longint angle;
    longint sq;
    longint term;
    longint part;
    int     n;
    angle = (64'sd1686629713 * idx) / TABLE_DEPTH;
    sq    = (angle * angle) >>> 30;
    term  = 64'sd1 <<< 30;
    for (n = 0; n < 7; n++) begin
      part = (term > 0) ? ((sq * term) >>> 30) / ((14 - 2 * n) * (13 - 2 * n)) : 64'sd0;
      term = (64'sd1 <<< 30) - part;
    end
    if (term < 0) begin
      term = 0;
    end
    term = (term + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (term > (64'sd1 <<< FRAC_BITS)) begin
      term = 64'sd1 <<< FRAC_BITS;
    end
    return term[31:0];
  endfunction

  // The two top phase bits pick the quadrant. Quadrants one and three read
  // the table mirrored, and the entry one past the end of the table is zero.
  function automatic logic signed [31:0] cos_drive(logic [15:0] phase);
    int idx;
    int mirror;
    logic signed [31:0] near;
    logic signed [31:0] far;
    idx    = phase[13:0];
    idx    = (idx * TABLE_DEPTH) >> 14;
    mirror = TABLE_DEPTH - idx;
    near   = cos_rom[idx];
    far    = (mirror < TABLE_DEPTH) ? cos_rom[mirror] : 32'sd0;
    case (phase[15:14])
      2'd0: return near;
      2'd1: return -far;
      2'd2: return -near;
      default: return far;
    endcase
  endfunction

  // Spring, damping and drive terms, each product clamped on its own, and
  // then the sum clamped once more.
  function automatic logic signed [31:0] net_accel(logic signed [31:0] x,
                                                   logic signed [31:0] v,
                                                   logic [15:0] phase);
    longint sum;
    sum = 64'sd0 - q_mul($signed({1'b0, k_over_m}), x, FRAC_BITS)
          - q_mul($signed({1'b0, b_over_m}), v, FRAC_BITS)
          + q_mul(f_over_m, cos_drive(phase), FRAC_BITS);
    return clip_s32(sum);
  endfunction

  // Applies one accepted beat to the local state. A start beat seeds the
  // two positions with a Taylor first step and gives no result; its clamp
  // indication is dropped. A step beat queues the result that it must give.
  task automatic advance_oscillator(in_item_t item);
    logic signed [31:0] dt;
    logic signed [31:0] x_start;
    logic signed [31:0] v_start;
    logic signed [31:0] acc;
    logic signed [31:0] acc_dt;
    logic signed [31:0] acc_dt2;
    logic signed [31:0] x_next;
    logic signed [31:0] span;
    logic signed [31:0] vel;
    logic [63:0]        vel_sq;
    logic [63:0]        pos_sq;
    logic [63:0]        stiff;
    logic [63:0]        energy;
    logic [15:0]        phase;
    longint             sum;
    out_item_t          want;
    dt        = $signed({1'b0, dt_q});
    clip_flag = 1'b0;
    if (item.operation == OP_START) begin
      x_start  = item.initial_position;
      v_start  = item.initial_velocity;
      acc      = net_accel(x_start, v_start, phase_zero);
      acc_dt   = q_mul(acc, dt, FRAC_BITS);
      sum      = 64'sd0 + x_start + q_mul(v_start, dt, FRAC_BITS)
                 + q_mul(acc_dt, dt, FRAC_BITS + 1);
      x_prev   = x_start;
      x_now    = clip_s32(sum);
      v_now    = v_start;
      drive_ph = '0;
      step_ctr = '0;
    end else begin
      phase   = phase_zero + drive_ph;
      acc     = net_accel(x_now, v_now, phase);
      acc_dt  = q_mul(acc, dt, FRAC_BITS);
      acc_dt2 = q_mul(acc_dt, dt, FRAC_BITS);
      x_next  = clip_s32(64'sd2 * x_now - x_prev + acc_dt2);
      span    = clip_s32(64'sd0 + x_next - x_prev);
      vel     = q_mul(span, $signed({1'b0, half_inv_q}), FRAC_BITS);
      vel_sq  = q_square(vel);
      pos_sq  = q_square(x_now);
      stiff   = clip_u32(({33'd0, k_over_m} * {33'd0, mass_q}
                          + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      energy  = clip_u32(q_half_product({33'd0, mass_q}, vel_sq)
                         + q_half_product(stiff, pos_sq));
      want.step_index   = step_ctr;
      want.position     = x_now;
      want.velocity     = vel;
      want.acceleration = acc;
      want.energy       = energy[31:0];
      want.saturated    = clip_flag;
      pending_steps.push_back(want);
      x_prev   = x_now;
      x_now    = x_next;
      v_now    = vel;
      drive_ph = drive_ph + phase_step;
      step_ctr = step_ctr + 32'd1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Channel and register drivers
  // --------------------------------------------------------------------------

  // Presents one beat after a random gap. Valid stays high after acceptance
  // until the next call or a settle, so back-to-back beats never drop valid.
  task automatic send_item(in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    advance_oscillator(item);
  endtask

  task automatic send_start(logic [31:0] x0, logic [31:0] v0);
    in_item_t item;
    item.operation        = OP_START;
    item.initial_position = x0;
    item.initial_velocity = v0;
    send_item(item);
  endtask

  // Step beats carry random position and velocity fields, which the core
  // must ignore.
  task automatic send_steps(int count);
    in_item_t item;
    repeat (count) begin
      item.operation        = OP_STEP;
      item.initial_position = $urandom;
      item.initial_velocity = $urandom;
      send_item(item);
    end
  endtask

  // Holds the input channel until every queued result has been taken and a
  // start beat that is still in flight has had time to finish.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the write enable is back low before the task returns.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TIME_STEP:          dt_q       = value[30:0];
      REG_HALF_INVERSE_STEP:  half_inv_q = value[30:0];
      REG_STIFFNESS_PER_MASS: k_over_m   = value[30:0];
      REG_DAMPING_PER_MASS:   b_over_m   = value[30:0];
      REG_FORCE_PER_MASS:     f_over_m   = value;
      REG_PHASE_INCREMENT:    phase_step = value[15:0];
      REG_PHASE_OFFSET:       phase_zero = value[15:0];
      default:                mass_q     = value[30:0];
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] dt, logic [31:0] hinv, logic [31:0] k,
                             logic [31:0] b, logic [31:0] f, logic [31:0] pinc,
                             logic [31:0] poff, logic [31:0] m);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_HALF_INVERSE_STEP, hinv);
    write_reg(REG_STIFFNESS_PER_MASS, k);
    write_reg(REG_DAMPING_PER_MASS, b);
    write_reg(REG_FORCE_PER_MASS, f);
    write_reg(REG_PHASE_INCREMENT, pinc);
    write_reg(REG_PHASE_OFFSET, poff);
    write_reg(REG_MASS, m);
  endtask

  // --------------------------------------------------------------------------
  // Random value sources
  // --------------------------------------------------------------------------

  // Positions and velocities: mostly a few units around zero, so that the
  // oscillator really swings, with full-range words and the corners mixed in.
  function automatic logic [31:0] pick_state_value();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 32'h7FFF_FFFF;
    if (roll == 1) return 32'h8000_0000;
    if (roll == 2) return 32'h0000_0000;
    if (roll == 3) return 32'hFFFF_FFFF;
    if (roll < 8) return $urandom;
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  // A 31-bit register: its bounds or a random word now and then, otherwise a typical value.
  function automatic logic [31:0] pick_reg31(logic [31:0] lo, logic [31:0] typ_lo,
                                             logic [31:0] typ_hi);
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return lo;
    if (roll == 1) return U31_MAX;
    if (roll == 2) return $urandom & U31_MAX;
    return $urandom_range(typ_lo, typ_hi);
  endfunction

  task automatic randomize_registers();
    logic [31:0] dt;
    logic [31:0] hinv;
    logic [31:0] f;
    logic [31:0] pinc;
    int          roll;
    dt = pick_reg31(32'd1, 32'd16, 32'd6554);
    // Usually the true reciprocal of twice the step, sometimes anything.
    if ($urandom_range(0, 3) != 0) begin
      hinv = (dt < 2) ? U31_MAX : (32'h8000_0000 / dt);
    end else begin
      hinv = pick_reg31(32'd0, 32'd0, 32'h0100_0000);
    end
    roll = $urandom_range(0, 7);
    if (roll == 0) begin
      f = 32'h8000_0000;
    end else if (roll == 1) begin
      f = 32'h7FFF_FFFF;
    end else if (roll == 2) begin
      f = $urandom;
    end else begin
      f = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    end
    roll = $urandom_range(0, 7);
    if (roll == 0) begin
      pinc = 32'd0;
    end else if (roll == 1) begin
      pinc = 32'hFFFF;
    end else if (roll < 4) begin
      pinc = $urandom_range(0, 16'hFFFF);
    end else begin
      pinc = $urandom_range(0, 2048);
    end
    load_config(dt, hinv, pick_reg31(32'd1, 32'h1000, 32'h0040_0000),
                pick_reg31(32'd0, 32'd0, 32'h0004_0000), f, pinc,
                $urandom_range(0, 16'hFFFF), pick_reg31(32'd1, 32'h1000, 32'h0010_0000));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Steps straight out of reset run on the all-zero state with default
  // registers.
  task automatic test_step_before_start();
    send_steps(2);
  endtask

  // Starts from the corners of position and velocity under the defaults,
  // where the first step and the Verlet update clamp.
  task automatic test_state_extremes();
    send_start(POS_MAX, POS_MIN);
    send_steps(2);
    send_start(POS_MIN, POS_MAX);
    send_steps(1);
    send_start(32'h0000_0000, 32'h0000_0000);
    send_steps(1);
    send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_steps(1);
  endtask

  // Every register at its top, with the most negative drive, and then at
  // its bottom, with the most positive drive and a zero reciprocal.
  task automatic test_register_extremes();
    settle_block();
    load_config(U31_MAX, U31_MAX, U31_MAX, U31_MAX, 32'h8000_0000, 32'hFFFF,
                32'hFFFF, U31_MAX);
    send_start(32'h0001_0000, 32'hFFFF_0000);
    send_steps(2);
    settle_block();
    load_config(32'd1, 32'd0, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd1);
    send_start(POS_MIN, POS_MAX);
    send_steps(1);
  endtask

  // A quarter turn per step lands the drive on each quadrant boundary, where
  // the mirrored lookup reads the zero entry, and wraps the phase after four.
  task automatic test_drive_quadrants();
    settle_block();
    load_config(32'd655, 32'd3276800, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                32'h4000, 32'h0000, 32'h0001_0000);
    send_start(32'h0000_8000, 32'h0000_0000);
    send_steps(5);
  endtask

  // Mostly well-formed runs (a start, then a burst of steps with random
  // content), mixed with stray beats of either kind. The registers change
  // every eighty beats or so, each time after the core has gone quiet.
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    int       sent;
    int       burst;
    int       run;
    in_item_t noise;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      settle_block();
      randomize_registers();
      burst = 0;
      while (burst < 80 && sent < n_items) begin
        if ($urandom_range(0, 99) < 12) begin
          noise.operation        = $urandom_range(0, 1);
          noise.initial_position = pick_state_value();
          noise.initial_velocity = pick_state_value();
          send_item(noise);
          sent++;
          burst++;
        end else begin
          run = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
          send_start(pick_state_value(), pick_state_value());
          send_steps(run);
          sent  += run + 1;
          burst += run + 1;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    mismatch_count++;
  endtask

  // The receiver stalls at random. A result beat is taken at an edge where
  // valid and ready are both high, and it is checked against the oldest
  // prediction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_steps.pop_front();
        if (out_data.step_index !== want.step_index) begin
          report_field("step_index", want.step_index, out_data.step_index);
        end
        if (out_data.position !== want.position) begin
          report_field("position", want.position, out_data.position);
        end
        if (out_data.velocity !== want.velocity) begin
          report_field("velocity", want.velocity, out_data.velocity);
        end
        if (out_data.acceleration !== want.acceleration) begin
          report_field("acceleration", want.acceleration, out_data.acceleration);
        end
        if (out_data.energy !== want.energy) begin
          report_field("energy", want.energy, out_data.energy);
        end
        if (out_data.saturated !== want.saturated) begin
          report_field("saturated", {31'd0, want.saturated}, {31'd0, out_data.saturated});
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("driven_damped_oscillator_verlet_step_core test failed");
      $finish;
    end
  end

  initial begin : run_tests
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      cos_rom[i] = taylor_cos_entry(i);
    end
    // Register defaults and the cleared state, as the core holds them after
    // reset.
    dt_q       = 31'd655;
    half_inv_q = 31'd3276800;
    k_over_m   = 31'd65536;
    b_over_m   = 31'd0;
    f_over_m   = 32'sd0;
    phase_step = 16'd0;
    phase_zero = 16'd0;
    mass_q     = 31'd65536;
    x_prev     = 32'sd0;
    x_now      = 32'sd0;
    v_now      = 32'sd0;
    drive_ph   = 16'd0;
    step_ctr   = 32'd0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed tests run under the first idling mode.
    send_idle_pct  = 15;
    recv_stall_pct = 83;
    test_step_before_start();
    test_state_extremes();
    test_register_extremes();
    test_drive_quadrants();

    test_random_traffic(15, 83, ITEMS_PER_MODE);
    test_random_traffic(83, 15, ITEMS_PER_MODE);
    test_random_traffic(0, 0, ITEMS_PER_MODE);

    settle_block();
    if (mismatch_count == 0 && pending_steps.size() == 0) begin
      $display("driven_damped_oscillator_verlet_step_core test passed");
    end else begin
      $display("driven_damped_oscillator_verlet_step_core test failed");
    end
    $finish;
  end

endmodule
